>>> sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while the given active-low reset is low.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check a property on the default clock and reset of the module.
`define ASSERT_STD(label, prop) \
  `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

>>> sv/ccrc_pkg.sv
`timescale 1ns / 1ps

package ccrc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLYNOMIAL     = 3'd0,
    CFG_REFLECT_INPUT  = 3'd1,
    CFG_INITIAL_XOR    = 3'd2,
    CFG_REFLECT_OUTPUT = 3'd3,
    CFG_FINAL_XOR      = 3'd4
  } cfg_idx_e;

  localparam logic [31:0] PolyReset    = 32'h04C1_1DB7;
  localparam logic [31:0] InitXorReset = 32'hFFFF_FFFF;
  localparam logic [31:0] FinXorReset  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] polynomial;
    logic        reflect_input;
    logic [31:0] initial_xor;
    logic        reflect_output;
    logic [31:0] final_xor;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seed_value;
    logic        last_byte;
    logic        first_byte;
    logic        has_byte;
    logic [7:0]  data_byte;
  } item_t;

  function automatic logic [31:0] bitrev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

endpackage

>>> sv/ccrc_in_reg.sv
`timescale 1ns / 1ps

module ccrc_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  ccrc_pkg::item_t  s_item_i,
  input  logic             take_i,
  output logic             valid_o,
  output ccrc_pkg::item_t  item_o
);

  logic            valid_q, valid_d;
  ccrc_pkg::item_t item_q;
  logic            load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/ccrc_step.sv
`timescale 1ns / 1ps

module ccrc_step (
  input  ccrc_pkg::cfg_t  cfg_i,
  input  ccrc_pkg::item_t item_i,
  input  logic [31:0]     crc_i,
  output logic [31:0]     crc_next_o,
  output logic [31:0]     crc_value_o
);

  logic [31:0] start;
  logic [31:0] base;
  logic [31:0] rpoly;
  logic [31:0] folded;
  logic [31:0] norm;
  logic [31:0] outv;

  always_comb begin
    rpoly = ccrc_pkg::bitrev32(cfg_i.polynomial);
    start = cfg_i.reflect_input ? (item_i.seed_value ^ ccrc_pkg::bitrev32(cfg_i.initial_xor))
                                : cfg_i.initial_xor;
    base  = item_i.first_byte ? start : crc_i;

    // Eight shift-xor steps, one per message bit.
    if (cfg_i.reflect_input) begin
      folded = base ^ {24'd0, item_i.data_byte};
      for (int i = 0; i < 8; i++) begin
        folded = folded[0] ? ({1'b0, folded[31:1]} ^ rpoly) : {1'b0, folded[31:1]};
      end
    end else begin
      folded = base ^ {item_i.data_byte, 24'd0};
      for (int i = 0; i < 8; i++) begin
        folded = folded[31] ? ({folded[30:0], 1'b0} ^ cfg_i.polynomial)
                            : {folded[30:0], 1'b0};
      end
    end

    crc_next_o = item_i.has_byte ? folded : base;

    // Bring the register back to normal bit order, then apply output options.
    norm = cfg_i.reflect_input ? ccrc_pkg::bitrev32(crc_next_o) : crc_next_o;
    outv = cfg_i.reflect_output ? ccrc_pkg::bitrev32(norm) : norm;
    crc_value_o = outv ^ cfg_i.final_xor;
  end

endmodule

>>> sv/ccrc_out_reg.sv
`timescale 1ns / 1ps

module ccrc_out_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] data_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [31:0] m_data_o
);

  logic        valid_q, valid_d;
  logic [31:0] data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

>>> sv/configurable_crc32_byte_engine_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Configurable 32-bit CRC engine, one message byte per item. Throughput is one
// item per clock while the output register can take each result: an accepted
// item waits in an input register, and when it is consumed the eight unrolled
// shift-xor steps fold its byte into the running CRC register and, on tlast,
// load the finished CRC into the output register. The rate is set by the xor
// logic feeding the CRC register back to itself; a last item is held while the
// output is still full. Input tuser[0] marks that tdata carries a message byte
// (clear it for an empty message end), tuser[1] starts a new message. The user
// must write polynomial, reflection and xor values through the cfg port only
// while the engine is idle; the block does not enforce this. Reset gives CRC-32
// IEEE. In reflected mode the seed in tdata is xored into the start value.
module configurable_crc32_byte_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] seed_value
  input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] first_byte
  input  logic        s_axis_tlast,   // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] crc_value
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ccrc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  ccrc_pkg::cfg_t  cfg_q;
  ccrc_pkg::item_t s_item;
  ccrc_pkg::item_t item;
  logic            item_valid;
  logic            consume;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     crc_next;
  logic [31:0]     crc_value;

  // Unpack the slave stream into an item.
  always_comb begin
    s_item.data_byte  = s_axis_tdata[7:0];
    s_item.seed_value = s_axis_tdata[39:8];
    s_item.has_byte   = s_axis_tuser[0];
    s_item.first_byte = s_axis_tuser[1];
    s_item.last_byte  = s_axis_tlast;
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.polynomial     <= ccrc_pkg::PolyReset;
      cfg_q.reflect_input  <= 1'b1;
      cfg_q.initial_xor    <= ccrc_pkg::InitXorReset;
      cfg_q.reflect_output <= 1'b1;
      cfg_q.final_xor      <= ccrc_pkg::FinXorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccrc_pkg::CFG_POLYNOMIAL:     cfg_q.polynomial     <= cfg_data_i;
        ccrc_pkg::CFG_REFLECT_INPUT:  cfg_q.reflect_input  <= cfg_data_i[0];
        ccrc_pkg::CFG_INITIAL_XOR:    cfg_q.initial_xor    <= cfg_data_i;
        ccrc_pkg::CFG_REFLECT_OUTPUT: cfg_q.reflect_output <= cfg_data_i[0];
        ccrc_pkg::CFG_FINAL_XOR:      cfg_q.final_xor      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ccrc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (consume),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  // Advance the held item unless it must emit a CRC and the output is still full.
  assign consume = item_valid && (!item.last_byte || !m_axis_tvalid || m_axis_tready);

  ccrc_step u_step (
    .cfg_i       (cfg_q),
    .item_i      (item),
    .crc_i       (crc_q),
    .crc_next_o  (crc_next),
    .crc_value_o (crc_value)
  );

  // Running CRC register: update only when an item is consumed.
  assign crc_d = consume ? crc_next : crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  ccrc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (consume && item.last_byte),
    .data_i    (crc_value),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

  // A result shows up only after a last item was consumed.
  `ASSERT_STD(a_result_from_last, $rose(m_axis_tvalid) |-> $past(consume && item.last_byte))
  // Never load a result over one that is not taken.
  `ASSERT_STD(a_no_overwrite, (consume && item.last_byte) |-> (!m_axis_tvalid || m_axis_tready))
  // Hold the CRC register while no item is consumed.
  `ASSERT_STD(a_crc_hold, !consume |=> $stable(crc_q))
  // A held item that is not consumed stays in the input register.
  `ASSERT_STD(a_item_hold, (item_valid && !consume) |=> item_valid)

endmodule

>>> dv/tb_configurable_crc32_byte_engine_core.sv
`timescale 1ns / 1ps

module tb_configurable_crc32_byte_engine_core;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Indexes past the register list; writes there must leave every register alone.
  localparam logic [ccrc_pkg::CfgIdxW-1:0] CFG_IDX_SPARE_FIRST = 3'd5;
  localparam logic [ccrc_pkg::CfgIdxW-1:0] CFG_IDX_SPARE_LAST  = 3'd7;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [39:0]                   s_axis_tdata;   // [7:0] data_byte, [39:8] seed_value
  logic [1:0]                    s_axis_tuser;   // [0] has_byte, [1] first_byte
  logic                          s_axis_tlast;   // last_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [31:0]                   m_axis_tdata;   // [31:0] crc_value
  logic                          cfg_we_i;
  logic [ccrc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [31:0]                   cfg_data_i;

  configurable_crc32_byte_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the engine: register settings and running CRC.
  ccrc_pkg::cfg_t crc_cfg;
  logic [31:0]    crc_running;
  logic [31:0]    crc_expected_q [$];

  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned stalled_cycles;
  bit          src_idle_on;
  bit          sink_idle_on;
  bit          hold_request;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mirror32(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) r[31-k] = v[k];
    return r;
  endfunction

  // Fold one byte into the running register, eight shift-xor stages.
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                input logic [7:0] data);
    logic [31:0] rpoly;
    rpoly = mirror32(crc_cfg.polynomial);
    if (crc_cfg.reflect_input) begin
      crc = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ rpoly) : (crc >> 1);
    end else begin
      crc = crc ^ {data, 24'd0};
      for (int k = 0; k < 8; k++)
        crc = crc[31] ? ((crc << 1) ^ crc_cfg.polynomial) : (crc << 1);
    end
    return crc;
  endfunction

  // Advance the shadow by one accepted item; queue the CRC when the message ends.
  task automatic crc_predict(input ccrc_pkg::item_t it);
    logic [31:0] fin;
    if (it.first_byte)
      crc_running = crc_cfg.reflect_input ?
                    (it.seed_value ^ mirror32(crc_cfg.initial_xor)) : crc_cfg.initial_xor;
    if (it.has_byte) crc_running = crc_fold_byte(crc_running, it.data_byte);
    if (it.last_byte) begin
      fin = crc_cfg.reflect_input ? mirror32(crc_running) : crc_running;
      if (crc_cfg.reflect_output) fin = mirror32(fin);
      crc_expected_q.push_back(fin ^ crc_cfg.final_xor);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 90) return $urandom_range(1, 12);
    return $urandom_range(13, 48);
  endfunction

  function automatic logic [31:0] pick_word(input logic [31:0] typical);
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return typical;
      default: return $urandom;
    endcase
  endfunction

  function automatic ccrc_pkg::item_t random_item();
    ccrc_pkg::item_t it;
    it.data_byte  = 8'($urandom);
    it.seed_value = $urandom;
    it.has_byte   = 1'($urandom);
    it.first_byte = 1'($urandom);
    it.last_byte  = 1'($urandom);
    return it;
  endfunction

  function automatic ccrc_pkg::cfg_t random_crc_cfg();
    ccrc_pkg::cfg_t c;
    c.polynomial     = pick_word(ccrc_pkg::PolyReset);
    c.reflect_input  = 1'($urandom);
    c.initial_xor    = pick_word(ccrc_pkg::InitXorReset);
    c.reflect_output = 1'($urandom);
    c.final_xor      = pick_word(ccrc_pkg::FinXorReset);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one item after an optional gap and hold it until accepted.
  task automatic send_item(input ccrc_pkg::item_t it);
    int unsigned gap;
    gap = src_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.seed_value, it.data_byte};
    s_axis_tuser  <= {it.first_byte, it.has_byte};
    s_axis_tlast  <= it.last_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    crc_predict(it);
    items_sent++;
  endtask

  // Send a message of len bytes (len 0: one empty end item). With holes, some
  // items carry no byte; without first, the message continues the register.
  task automatic send_message(input int unsigned len, input bit with_first,
                              input bit with_holes, input logic [31:0] seed);
    ccrc_pkg::item_t it;
    int unsigned     n;
    n = (len == 0) ? 1 : len;
    for (int unsigned i = 0; i < n; i++) begin
      it            = random_item();
      it.first_byte = with_first && (i == 0);
      it.has_byte   = (len != 0) && !(with_holes && $urandom_range(0, 3) == 0);
      it.last_byte  = (i == n - 1);
      if (i == 0) it.seed_value = seed;
      send_item(it);
    end
  endtask

  // Drop valid, wait for every queued CRC, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ccrc_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      ccrc_pkg::CFG_POLYNOMIAL:     crc_cfg.polynomial     = value;
      ccrc_pkg::CFG_REFLECT_INPUT:  crc_cfg.reflect_input  = value[0];
      ccrc_pkg::CFG_INITIAL_XOR:    crc_cfg.initial_xor    = value;
      ccrc_pkg::CFG_REFLECT_OUTPUT: crc_cfg.reflect_output = value[0];
      ccrc_pkg::CFG_FINAL_XOR:      crc_cfg.final_xor      = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input ccrc_pkg::cfg_t c);
    write_reg(ccrc_pkg::CFG_POLYNOMIAL,     c.polynomial);
    write_reg(ccrc_pkg::CFG_REFLECT_INPUT,  {31'd0, c.reflect_input});
    write_reg(ccrc_pkg::CFG_INITIAL_XOR,    c.initial_xor);
    write_reg(ccrc_pkg::CFG_REFLECT_OUTPUT, {31'd0, c.reflect_output});
    write_reg(ccrc_pkg::CFG_FINAL_XOR,      c.final_xor);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Without a start flag the bytes continue from the register, zero after reset.
  task automatic test_reset_carry_over();
    ccrc_pkg::item_t it;
    it = random_item();
    it.data_byte = 8'hA5; it.has_byte = 1'b1; it.first_byte = 1'b0; it.last_byte = 1'b1;
    send_item(it);
    // Close again with no byte: same register, same CRC.
    it = random_item();
    it.has_byte = 1'b0; it.first_byte = 1'b0; it.last_byte = 1'b1;
    send_item(it);
  endtask

  task automatic test_known_vectors();
    logic [7:0]      check_msg [0:8];
    ccrc_pkg::item_t it;
    check_msg = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    for (int i = 0; i < 9; i++) begin
      it.data_byte  = check_msg[i];
      it.seed_value = 32'd0;
      it.has_byte   = 1'b1;
      it.first_byte = (i == 0);
      it.last_byte  = (i == 8);
      send_item(it);
    end
    // Empty message, then single-byte messages at the field extremes.
    send_message(0, 1'b1, 1'b0, 32'd0);
    it = '{seed_value: 32'd0, last_byte: 1'b1, first_byte: 1'b1, has_byte: 1'b1,
           data_byte: 8'h00};
    send_item(it);
    it = '{seed_value: 32'hFFFF_FFFF, last_byte: 1'b1, first_byte: 1'b1, has_byte: 1'b1,
           data_byte: 8'hFF};
    send_item(it);
    // Byte-less item inside a message.
    it = '{seed_value: $urandom, last_byte: 1'b0, first_byte: 1'b1, has_byte: 1'b1,
           data_byte: 8'h5A};
    send_item(it);
    it = '{seed_value: $urandom, last_byte: 1'b0, first_byte: 1'b0, has_byte: 1'b0,
           data_byte: 8'hC3};
    send_item(it);
    it = '{seed_value: $urandom, last_byte: 1'b1, first_byte: 1'b0, has_byte: 1'b1,
           data_byte: 8'h3C};
    send_item(it);
    // Restart in the middle of a message: the second start discards the first.
    it = '{seed_value: $urandom, last_byte: 1'b0, first_byte: 1'b1, has_byte: 1'b1,
           data_byte: 8'h81};
    send_item(it);
    it = '{seed_value: $urandom, last_byte: 1'b0, first_byte: 1'b1, has_byte: 1'b1,
           data_byte: 8'h7E};
    send_item(it);
    it = '{seed_value: $urandom, last_byte: 1'b1, first_byte: 1'b0, has_byte: 1'b0,
           data_byte: 8'h00};
    send_item(it);
  endtask

  task automatic test_config_extremes();
    ccrc_pkg::cfg_t sweep [6];
    sweep[0] = '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000};
    sweep[1] = '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF};
    sweep[2] = '{ccrc_pkg::PolyReset, 1'b0, ccrc_pkg::InitXorReset, 1'b0,
                 ccrc_pkg::FinXorReset};
    sweep[3] = '{32'h1EDC_6F41, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000};
    sweep[4] = '{32'h0000_0001, 1'b1, 32'h8000_0000, 1'b1, 32'h5555_AAAA};
    sweep[5] = '{ccrc_pkg::PolyReset, 1'b1, ccrc_pkg::InitXorReset, 1'b1,
                 ccrc_pkg::FinXorReset};
    foreach (sweep[s]) begin
      wait_idle();
      load_config(sweep[s]);
      if (s == 3) begin
        // Upper bits of the one-bit registers are masked, spare indexes ignored.
        write_reg(ccrc_pkg::CFG_REFLECT_INPUT,  32'hFFFF_FFFE);
        write_reg(ccrc_pkg::CFG_REFLECT_OUTPUT, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_SPARE_FIRST, 32'hDEAD_BEEF);
        write_reg(CFG_IDX_SPARE_LAST,  32'hFFFF_FFFF);
      end
      repeat (3) send_message($urandom_range(0, 6), 1'b1, 1'b0, $urandom);
    end
  endtask

  // Stall the result side for a long stretch while items keep coming.
  task automatic test_output_hold_off();
    wait_idle();
    src_idle_on  = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_message(1, 1'b1, 1'b0, $urandom);
    src_idle_on  = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned r;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      load_config(phase == 0 ? ccrc_pkg::cfg_t'{ccrc_pkg::PolyReset, 1'b1,
                                                ccrc_pkg::InitXorReset, 1'b1,
                                                ccrc_pkg::FinXorReset}
                             : random_crc_cfg());
      // One phase runs back to back on both sides.
      src_idle_on  = (phase != 2);
      sink_idle_on = (phase != 2);
      target = items_sent + 105;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 70)      send_message(pick_len(), 1'b1, 1'b0, $urandom);
        else if (r < 82) send_message(pick_len(), 1'b1, 1'b1, $urandom);
        else if (r < 90) send_message(pick_len(), 1'b0, 1'b0, $urandom);
        else             send_item(random_item());
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, with the long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted CRC with the oldest prediction; watch for a hang.
  always @(posedge clk_i) begin
    logic [31:0] crc_exp;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (crc_expected_q.size() == 0) begin
          $display("%0t: unexpected CRC result, expected none actual %h", $time,
                   m_axis_tdata);
          mismatch_count++;
        end else begin
          crc_exp = crc_expected_q.pop_front();
          if (m_axis_tdata !== crc_exp) begin
            $display("%0t: crc_value mismatch, expected %h actual %h", $time, crc_exp,
                     m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stalled_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    s_axis_tlast   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = ccrc_pkg::CFG_POLYNOMIAL;
    cfg_data_i     = '0;
    crc_cfg        = '{ccrc_pkg::PolyReset, 1'b1, ccrc_pkg::InitXorReset, 1'b1,
                       ccrc_pkg::FinXorReset};
    crc_running    = '0;
    items_sent     = 0;
    mismatch_count = 0;
    stalled_cycles = 0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    hold_request   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_carry_over();
    test_known_vectors();
    test_config_extremes();
    test_output_hold_off();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
